[rtl/stg_pkg.sv]
// Shared types and constants for the trapezoidal step generator.
package stg_pkg;

    // Default widths
    localparam int MOVE_LEN_BITS_DEF = 24;
    localparam int POS_BITS_DEF      = 32;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_MOVE  = 2'd1;
    localparam logic [1:0] CMD_ESTOP = 2'd2;

    // Register indexes (word address paddr[4:2])
    localparam logic [2:0] REG_ACCEL_RATE  = 3'd0;
    localparam logic [2:0] REG_MAX_SPEED   = 3'd1;
    localparam logic [2:0] REG_MIN_INTV    = 3'd2;
    localparam logic [2:0] REG_PULSE_WIDTH = 3'd3;
    localparam logic [2:0] REG_FIRST_INTV  = 3'd4;
    localparam logic [2:0] REG_DIR_INVERT  = 3'd5;

    // Register reset values
    localparam logic [19:0] ACCEL_RST   = 20'd1440;
    localparam logic [19:0] MAXSPD_RST  = 20'd200;
    localparam logic [19:0] MININTV_RST = 20'd5000;
    localparam logic [15:0] PW_RST      = 16'd5;
    localparam logic [23:0] FIRST_RST   = 24'd25203;

    // Arithmetic constants
    localparam logic [39:0] US_PER_S   = 40'd1000000;
    localparam int          DIV_STEPS  = 40;
    localparam int          SQRT_STEPS = 16;
    localparam logic [31:0] SQRT_BIT0  = 32'h4000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_DIV,
        ST_PLAN,
        ST_CLAMP,
        ST_FIN
    } t_state;

endpackage

[rtl/stepper_trapezoid_step_generator_core.sv]
// Trapezoidal stepper step generator: top level with sequencer and shared divider.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------------
//  in      | to core   | i_in_valid / o_in_stall   | i_cmd, i_move_value, i_move_absolute
//  out     | from core | o_out_valid / i_out_stall | o_step_pulse, o_dir_level,
//          |           |                           | o_next_interval_us, o_moving,
//          |           |                           | o_position, o_steps_left
//  cfg     | to core   | APB psel/penable/pready   | paddr, pwdata, prdata
//
//  Steps per item, after the idle state takes the transfer: a ramp tick runs one multiply,
//  16 root iterations, 40 restoring-divide iterations on the shared shift/subtract unit,
//  clamp and result load; a move runs a 40-iteration ramp-length divide, plan and load, or
//  only plan and load with zero acceleration; a cruise tick runs clamp and load; idle ticks,
//  zero moves, emergency stop and unused commands go straight to the result load.
//  Reset is synchronous, active low; it clears the motion state and loads register defaults.
//  A stalled result holds in the output register; the input stalls until that transfer.
module stepper_trapezoid_step_generator_core #(
    parameter int MOVE_LEN_BITS = stg_pkg::MOVE_LEN_BITS_DEF,
    parameter int POS_BITS      = stg_pkg::POS_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_move_value,
    input  logic               i_move_absolute,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_step_pulse,
    output logic               o_dir_level,
    output logic [23:0]        o_next_interval_us,
    output logic               o_moving,
    output logic signed [31:0] o_position,
    output logic [23:0]        o_steps_left,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int L  = MOVE_LEN_BITS;
    localparam int P  = POS_BITS;
    // wide enough for an exact position difference or a 32-bit relative move
    localparam int DW = ((P > 32) ? P : 32) + 1;
    localparam logic [L-1:0] LEN_MAX = {L{1'b1}};

    // configuration registers
    logic [19:0] r_accel, r_max_speed, r_min_intv;
    logic [15:0] r_pulse_w;
    logic [23:0] r_first_intv;
    logic        r_dir_inv;

    // motion state
    logic signed [P-1:0] r_cur;
    logic [L-1:0]        r_rem, r_total, r_ramp, r_decel;
    logic                r_run, r_fwd;

    // sequencer and shared unit
    stg_pkg::t_state r_state, n_state;
    logic [5:0]      r_cnt;
    logic            r_is_move;
    logic [39:0]     r_dvd;        // dividend, shifts into quotient
    logic [20:0]     r_dvs;
    logic [20:0]     r_rem_div;
    logic [31:0]     r_sq, r_root, r_bit;
    logic [L:0]      r_n;
    logic [23:0]     r_interval;
    logic            r_pulse;

    // output register
    logic            r_out_valid;
    logic            r_o_pulse, r_o_dir, r_o_moving;
    logic [23:0]     r_o_intv, r_o_left;
    logic [31:0]     r_o_pos;

    logic accept_in, take_out, cfg_wr;
    assign accept_in = i_in_valid && !o_in_stall;
    assign take_out  = r_out_valid && !i_out_stall;
    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;

    // ---------------- configuration port ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel      <= stg_pkg::ACCEL_RST;
            r_max_speed  <= stg_pkg::MAXSPD_RST;
            r_min_intv   <= stg_pkg::MININTV_RST;
            r_pulse_w    <= stg_pkg::PW_RST;
            r_first_intv <= stg_pkg::FIRST_RST;
            r_dir_inv    <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                stg_pkg::REG_ACCEL_RATE:  r_accel      <= pwdata[19:0];
                stg_pkg::REG_MAX_SPEED:   r_max_speed  <= pwdata[19:0];
                stg_pkg::REG_MIN_INTV:    r_min_intv   <= pwdata[19:0];
                stg_pkg::REG_PULSE_WIDTH: r_pulse_w    <= pwdata[15:0];
                stg_pkg::REG_FIRST_INTV:  r_first_intv <= pwdata[23:0];
                stg_pkg::REG_DIR_INVERT:  r_dir_inv    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            stg_pkg::REG_ACCEL_RATE:  prdata = 32'(r_accel);
            stg_pkg::REG_MAX_SPEED:   prdata = 32'(r_max_speed);
            stg_pkg::REG_MIN_INTV:    prdata = 32'(r_min_intv);
            stg_pkg::REG_PULSE_WIDTH: prdata = 32'(r_pulse_w);
            stg_pkg::REG_FIRST_INTV:  prdata = 32'(r_first_intv);
            stg_pkg::REG_DIR_INVERT:  prdata = 32'(r_dir_inv);
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------- decode of the accepted item ----------------
    logic [16:0]         min_pw;
    logic                tick_active;
    logic [L-1:0]        rem_dec, done_cnt;
    logic                in_accel_ramp, in_decel_ramp;
    logic signed [P-1:0] tgt;
    logic signed [DW-1:0] diff;
    logic [DW-1:0]       mag;
    logic                mv_fwd, mv_go;
    logic [L-1:0]        mv_len;
    logic [23:0]         first_clamped;

    assign min_pw        = {r_pulse_w, 1'b0};
    assign tick_active   = r_run && (r_rem != '0);
    assign rem_dec       = r_rem - L'(1);
    assign done_cnt      = r_total - rem_dec;
    assign in_accel_ramp = done_cnt <= r_ramp;
    assign in_decel_ramp = done_cnt >= r_decel;

    assign tgt  = P'(i_move_value);
    assign diff = i_move_absolute ? (DW'(tgt) - DW'(r_cur)) : DW'(i_move_value);
    assign mv_fwd = !diff[DW-1] && (diff != '0);
    assign mag    = diff[DW-1] ? DW'(-diff) : DW'(diff);
    assign mv_go  = mag != '0;
    assign mv_len = (mag > DW'(LEN_MAX)) ? LEN_MAX : mag[L-1:0];
    assign first_clamped = (r_first_intv < 24'(min_pw)) ? 24'(min_pw) : r_first_intv;

    // ---------------- shared shift/subtract unit ----------------
    logic [21:0] div_sh;
    logic        div_ge;
    logic [21:0] div_nx;
    assign div_sh = {r_rem_div, r_dvd[39]};
    assign div_ge = div_sh >= {1'b0, r_dvs};
    assign div_nx = div_ge ? (div_sh - {1'b0, r_dvs}) : div_sh;

    logic [32:0] sq_sum;
    logic        sq_ge;
    logic [31:0] root_nx;
    assign sq_sum  = {1'b0, r_root} + {1'b0, r_bit};
    assign sq_ge   = {1'b0, r_sq} >= sq_sum;
    assign root_nx = sq_ge ? ((r_root >> 1) + r_bit) : (r_root >> 1);

    // speed from the root as it stands after the current iteration
    logic [15:0] speed;
    assign speed = (root_nx[15:0] == 16'd0) ? 16'd1 : root_nx[15:0];

    logic [52:0] ramp_prod;
    assign ramp_prod = {r_accel, 1'b0} * 32'(r_n);

    logic [39:0] need;
    logic        half_ramp;
    logic [L-1:0] ramp_sel;
    assign need      = r_dvd;
    assign half_ramp = (r_is_move && r_accel == 20'd0) || ({need, 1'b0} >= 41'(r_total));
    assign ramp_sel  = half_ramp ? (r_total >> 1) : need[L-1:0];

    logic [19:0] clamp_a, clamp_b;
    assign clamp_a = (r_dvd[19:0] < 20'(min_pw)) ? 20'(min_pw) : r_dvd[19:0];
    assign clamp_b = (clamp_a < r_min_intv) ? r_min_intv : clamp_a;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        case (r_state)
            stg_pkg::ST_IDLE: begin
                o_in_stall = r_out_valid && i_out_stall;
                if (accept_in) begin
                    n_state = stg_pkg::ST_FIN;
                    if (i_cmd == stg_pkg::CMD_TICK && tick_active) begin
                        n_state = (in_accel_ramp || in_decel_ramp) ? stg_pkg::ST_MUL
                                                                  : stg_pkg::ST_CLAMP;
                    end else if (i_cmd == stg_pkg::CMD_MOVE && mv_go) begin
                        n_state = (r_accel == 20'd0) ? stg_pkg::ST_PLAN : stg_pkg::ST_DIV;
                    end
                end
            end
            stg_pkg::ST_MUL:   n_state = stg_pkg::ST_SQRT;
            stg_pkg::ST_SQRT:  if (r_cnt == 6'd0) n_state = stg_pkg::ST_DIV;
            stg_pkg::ST_DIV: begin
                if (r_cnt == 6'd0) begin
                    n_state = r_is_move ? stg_pkg::ST_PLAN : stg_pkg::ST_CLAMP;
                end
            end
            stg_pkg::ST_PLAN:  n_state = stg_pkg::ST_FIN;
            stg_pkg::ST_CLAMP: n_state = stg_pkg::ST_FIN;
            stg_pkg::ST_FIN:   n_state = stg_pkg::ST_IDLE;
            default:           n_state = stg_pkg::ST_IDLE;
        endcase
    end

    // motion state: reset clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_rem   <= '0;
            r_total <= '0;
            r_ramp  <= '0;
            r_decel <= '0;
            r_run   <= 1'b0;
            r_fwd   <= 1'b0;
        end else if (r_state == stg_pkg::ST_IDLE && accept_in) begin
            case (i_cmd)
                stg_pkg::CMD_TICK: begin
                    if (!tick_active) begin
                        r_run <= 1'b0;
                    end else begin
                        // advance one step toward the target
                        r_cur <= r_fwd ? r_cur + P'(1) : r_cur - P'(1);
                        r_rem <= rem_dec;
                    end
                end
                stg_pkg::CMD_MOVE: begin
                    if (mv_go) begin
                        r_fwd   <= mv_fwd;
                        r_total <= mv_len;
                        r_rem   <= mv_len;
                        r_run   <= 1'b1;
                    end
                end
                stg_pkg::CMD_ESTOP: begin
                    r_run <= 1'b0;
                    r_rem <= '0;
                end
                default: ;
            endcase
        end else if (r_state == stg_pkg::ST_PLAN) begin
            r_ramp  <= ramp_sel;
            r_decel <= r_total - ramp_sel;
        end
    end

    // datapath of the shared unit; payload only
    always_ff @(posedge i_clk) begin
        case (r_state)
            stg_pkg::ST_IDLE: begin
                r_rem_div <= '0;
                if (accept_in) begin
                    r_is_move <= (i_cmd == stg_pkg::CMD_MOVE);
                    if (i_cmd == stg_pkg::CMD_TICK && tick_active) begin
                        r_pulse    <= 1'b1;
                        r_interval <= 24'd0;
                        // ramp position: steps done, or steps left before this one
                        r_n        <= in_accel_ramp ? {1'b0, done_cnt} : {1'b0, r_rem};
                        r_dvd      <= 40'(r_min_intv);
                    end else if (i_cmd == stg_pkg::CMD_MOVE && mv_go) begin
                        r_pulse    <= 1'b0;
                        r_interval <= first_clamped;
                        r_dvd      <= 40'(r_max_speed * r_max_speed);
                        r_dvs      <= {r_accel, 1'b0};
                        r_cnt      <= 6'(stg_pkg::DIV_STEPS - 1);
                    end else begin
                        r_pulse    <= 1'b0;
                        r_interval <= 24'd0;
                    end
                end else begin
                    r_pulse    <= 1'b0;
                    r_interval <= 24'd0;
                end
            end
            stg_pkg::ST_MUL: begin
                r_sq   <= ramp_prod[31:0];
                r_root <= 32'd0;
                r_bit  <= stg_pkg::SQRT_BIT0;
                r_cnt  <= 6'(stg_pkg::SQRT_STEPS - 1);
            end
            stg_pkg::ST_SQRT: begin
                if (sq_ge) begin
                    r_sq <= r_sq - sq_sum[31:0];
                end
                r_root <= root_nx;
                r_bit  <= r_bit >> 2;
                if (r_cnt == 6'd0) begin
                    // hand over to the divider: one million over the speed
                    r_dvd     <= stg_pkg::US_PER_S;
                    r_dvs     <= {5'd0, speed};
                    r_rem_div <= '0;
                    r_cnt     <= 6'(stg_pkg::DIV_STEPS - 1);
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
            stg_pkg::ST_DIV: begin
                r_rem_div <= div_nx[20:0];
                r_dvd     <= {r_dvd[38:0], div_ge};
                r_cnt     <= r_cnt - 6'd1;
            end
            stg_pkg::ST_CLAMP: r_interval <= 24'(clamp_b);
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == stg_pkg::ST_FIN) begin
            r_out_valid <= 1'b1;
        end else if (take_out) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == stg_pkg::ST_FIN) begin
            r_o_pulse  <= r_pulse;
            r_o_dir    <= r_fwd ^ r_dir_inv;
            r_o_intv   <= r_interval;
            r_o_moving <= r_run;
            r_o_pos    <= 32'(64'(r_cur));
            r_o_left   <= 24'(r_rem);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_step_pulse       = r_o_pulse;
    assign o_dir_level        = r_o_dir;
    assign o_next_interval_us = r_o_intv;
    assign o_moving           = r_o_moving;
    assign o_position         = r_o_pos;
    assign o_steps_left       = r_o_left;

    // ---------------- assertions ----------------
    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == stg_pkg::ST_FIN |=> r_out_valid)
        else $error("result not loaded after finish");

    a_idle_no_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run |-> r_rem == '0)
        else $error("steps left while stopped");

    a_root_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == stg_pkg::ST_SQRT |-> $onehot(r_bit))
        else $error("root trial bit lost");

    a_ramp_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == stg_pkg::ST_IDLE |-> r_ramp <= r_decel)
        else $error("ramp ends after deceleration start");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != stg_pkg::ST_IDLE |-> o_in_stall)
        else $error("input taken while busy");

endmodule
